FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/atd_pkg.sv
package atd_pkg;

  localparam int TIMER_WIDTH_DEF = 32;
  localparam int ELAPSED_W       = 32;
  localparam int DELAY_W         = 32;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_RISE_DELAY    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_DELAY    = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_MODE    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_LEVEL = CFG_INDEX_W'(3);

  typedef struct packed {
    logic [DELAY_W-1:0] rise_delay;
    logic [DELAY_W-1:0] fall_delay;
    logic               clear_mode;
  } cfg_t;

endpackage

FILE: hw/rtl/atd_step.sv
module atd_step #(
  parameter int TIMER_WIDTH = atd_pkg::TIMER_WIDTH_DEF
) (
  input  atd_pkg::cfg_t                    cfg,
  input  logic                             level,
  input  logic [TIMER_WIDTH-1:0]           timer,
  input  logic                             raw_level,
  input  logic [atd_pkg::ELAPSED_W-1:0]    elapsed,
  output logic                             level_next,
  output logic [TIMER_WIDTH-1:0]           timer_next
);
  import atd_pkg::*;

  localparam int BASE_W = (TIMER_WIDTH > ELAPSED_W) ? TIMER_WIDTH : ELAPSED_W;
  localparam int SW     = BASE_W + 1;

  logic [SW-1:0] timer_ext;
  logic [SW-1:0] elapsed_ext;
  logic [SW-1:0] tmax_ext;
  logic [SW-1:0] sum;
  logic [SW-1:0] acc_ext;
  logic [SW-1:0] delay_ext;
  logic [SW-1:0] diff;
  logic [DELAY_W-1:0] delay;

  assign timer_ext   = {{(SW-TIMER_WIDTH){1'b0}}, timer};
  assign elapsed_ext = {{(SW-ELAPSED_W){1'b0}}, elapsed};
  assign tmax_ext    = {{(SW-TIMER_WIDTH){1'b0}}, {TIMER_WIDTH{1'b1}}};
  assign sum         = timer_ext + elapsed_ext;
  assign acc_ext     = (sum > tmax_ext) ? tmax_ext : sum;
  assign delay       = level ? cfg.fall_delay : cfg.rise_delay;
  assign delay_ext   = {{(SW-DELAY_W){1'b0}}, delay};
  assign diff        = timer_ext - elapsed_ext;

  always_comb begin
    level_next = level;
    timer_next = '0;
    if (raw_level != level) begin
      if (acc_ext >= delay_ext) begin
        level_next = raw_level;
      end else begin
        timer_next = acc_ext[TIMER_WIDTH-1:0];
      end
    end else if (!cfg.clear_mode && (timer_ext > elapsed_ext)) begin
      timer_next = diff[TIMER_WIDTH-1:0];
    end
  end

endmodule

FILE: hw/rtl/asymmetric_time_debounce.sv
// Asymmetric time-based debounce of one binary input.
// Input channel (in_valid/in_ready): raw_level and the time elapsed since
// the previous item. Output channel (out_valid/out_ready): debounced_level,
// exactly one result per input item, in order.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index
// 0 rise delay, 1 fall delay, 2 clear_mode, 3 initial_level (loads the level
// and clears the timer); other indexes are ignored. Write only while idle.
// An accepted item goes to the input register, then to the result register,
// loaded by one add/compare/subtract pass; out_valid rises with that load.
// Throughput: one item per cycle unless the receiver stalls; the timer and
// level update in the same cycle the item moves to the result register, so
// the next item sees it. When the receiver stalls, the result register holds,
// the input register fills behind it, and in_ready drops until out_ready
// returns. Reset (rst, synchronous): cfg, level, timer, in_full, out_valid
// zero, both channels empty; in_raw, in_elapsed, debounced_level not reset.
`include "assert_macros.svh"

module asymmetric_time_debounce #(
  parameter int TIMER_WIDTH = atd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              raw_level,
  input  logic [atd_pkg::ELAPSED_W-1:0]     elapsed,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              debounced_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [atd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [atd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import atd_pkg::*;

  cfg_t                   cfg;
  logic                   level;
  logic [TIMER_WIDTH-1:0] timer;
  logic                   level_next;
  logic [TIMER_WIDTH-1:0] timer_next;

  logic                   in_full;
  logic                   in_raw;
  logic [ELAPSED_W-1:0]   in_elapsed;
  logic                   out_adv;
  logic                   move;
  logic                   cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_adv   = !out_valid || out_ready;
  assign move      = in_full && out_adv;
  assign in_ready  = !in_full || out_adv;

  atd_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .level      (level),
    .timer      (timer),
    .raw_level  (in_raw),
    .elapsed    (in_elapsed),
    .level_next (level_next),
    .timer_next (timer_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg   <= '0;
      level <= 1'b0;
      timer <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_RISE_DELAY: cfg.rise_delay <= cfg_data[DELAY_W-1:0];
        REG_FALL_DELAY: cfg.fall_delay <= cfg_data[DELAY_W-1:0];
        REG_CLEAR_MODE: cfg.clear_mode <= cfg_data[0];
        REG_INITIAL_LEVEL: begin
          level <= cfg_data[0];
          timer <= '0;
        end
        default: ;
      endcase
    end else if (move) begin
      level <= level_next;
      timer <= timer_next;
    end
  end

  // hold the item until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_raw     <= raw_level;
      in_elapsed <= elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      debounced_level <= level_next;
    end
  end

  `ASSERT_NEXT(a_init_load, clk, rst, cfg_wr && (cfg_index == REG_INITIAL_LEVEL), (timer == '0) && (level == $past(cfg_data[0])), "initial_level write did not load level and clear timer")
  `ASSERT_NEXT(a_clear_mode, clk, rst, move && !cfg_wr && cfg.clear_mode && (in_raw == level), timer == '0, "timer not cleared on agreement in clear mode")
  `ASSERT_NEXT(a_level_hold, clk, rst, !move && !cfg_wr, $stable(level), "level changed without an item or a write")
  `ASSERT_NEXT(a_result_level, clk, rst, move && !cfg_wr, out_valid && (debounced_level == level), "result does not match updated level")
  `ASSERT_NOW(a_stall_cause, clk, rst, in_full && !in_ready, out_valid && !out_ready, "input stalled without a stalled result")

endmodule

FILE: tb/asymmetric_time_debounce_test.sv
module asymmetric_time_debounce_test;
  import atd_pkg::*;

  localparam int TW = TIMER_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PRINT_CAP = 40;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   raw;
    logic [CFG_DATA_W-1:0]  value;
    logic [CFG_INDEX_W-1:0] idx;
    logic                   typed;
    logic                   level;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   raw_level = 1'b0;
  logic [ELAPSED_W-1:0]   elapsed = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   debounced_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic                   level_now = 1'b0;
  logic [TW-1:0]          timer_now = '0;
  logic [DELAY_W-1:0]     on_delay = '0;
  logic [DELAY_W-1:0]     off_delay = '0;
  logic                   clear_on_agree = 1'b0;

  logic                   level_q[$];
  row_t                   dir_rows[$];
  int                     errors = 0;
  int                     cycle_count = 0;
  int                     stall_left = 0;
  int                     in_gap_pct = 0;
  int                     stall_pct = 0;
  logic                   quiet = 1'b0;
  logic                   want;

  asymmetric_time_debounce u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_level       (raw_level),
    .elapsed         (elapsed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .debounced_level (debounced_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("asymmetric_time_debounce test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  function automatic logic debounce_step(input logic raw, input logic [ELAPSED_W-1:0] el);
    logic [63:0] sum;
    logic [63:0] tmax;
    logic [63:0] limit;
    tmax = 64'({TW{1'b1}});
    limit = level_now ? 64'(off_delay) : 64'(on_delay);
    if (raw != level_now) begin
      sum = 64'(timer_now) + 64'(el);
      timer_now = (sum > tmax) ? TW'(tmax) : TW'(sum);
      if (64'(timer_now) >= limit) begin
        level_now = raw;
        timer_now = '0;
      end
    end else if (clear_on_agree) begin
      timer_now = '0;
    end else if (64'(timer_now) > 64'(el)) begin
      timer_now = TW'(64'(timer_now) - 64'(el));
    end else begin
      timer_now = '0;
    end
    return level_now;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = level_q.pop_front();
          if (debounced_level !== want)
            report_mismatch($sformatf("debounced_level %b, expected %b", debounced_level, want));
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(99) < stall_pct) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(7);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_level(input logic raw, input logic [ELAPSED_W-1:0] el,
                            input logic typed, input logic typed_level);
    logic predicted;
    in_valid <= 1'b1;
    raw_level <= raw;
    elapsed <= el;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = debounce_step(raw, el);
    level_q.push_back(typed ? typed_level : predicted);
    if (!quiet && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold until every item has come out, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (level_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RISE_DELAY: on_delay = data;
      REG_FALL_DELAY: off_delay = data;
      REG_CLEAR_MODE: clear_on_agree = data[0];
      REG_INITIAL_LEVEL: begin
        level_now = data[0];
        timer_now = '0;
      end
      default: ;
    endcase
  endtask

  task automatic add_item(input logic raw, input logic [ELAPSED_W-1:0] el,
                          input logic typed, input logic level);
    row_t r;
    r.kind = ROW_ITEM;
    r.raw = raw;
    r.value = el;
    r.idx = '0;
    r.typed = typed;
    r.level = level;
    dir_rows.push_back(r);
  endtask

  task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind = ROW_WRITE;
    r.raw = 1'b0;
    r.value = data;
    r.idx = idx;
    r.typed = 1'b0;
    r.level = 1'b0;
    dir_rows.push_back(r);
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 5) return DELAY_W'($urandom_range(1, 20));
    if (r <= 7) return DELAY_W'($urandom_range(21, 5000));
    return DELAY_W'($urandom);
  endfunction

  initial begin
    logic                 run_level;
    logic                 raw;
    int                   run_len;
    int                   n;
    int unsigned          r;
    logic [63:0]          span;
    logic [ELAPSED_W-1:0] el;

    // zero delays straight after reset
    add_item(1'b0, '0, 1'b1, 1'b0);
    add_item(1'b1, '0, 1'b1, 1'b1);
    add_item(1'b0, '1, 1'b1, 1'b0);
    // largest delays: saturation must still reach them
    add_write(REG_RISE_DELAY, '1);
    add_write(REG_FALL_DELAY, '1);
    add_item(1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_item(1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_item(1'b0, '1, 1'b0, 1'b0);
    add_item(1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0);
    add_item(1'b0, 32'd5, 1'b0, 1'b0);
    add_item(1'b1, 32'd5, 1'b0, 1'b0);
    // clear on agreement, upper data bits ignored
    add_write(REG_CLEAR_MODE, '1);
    add_item(1'b1, 32'h10, 1'b0, 1'b0);
    add_item(1'b0, '0, 1'b0, 1'b0);
    add_item(1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0);
    // unknown indexes leave everything alone
    add_write(REG_RISE_DELAY, 32'd3);
    add_write(REG_FALL_DELAY, 32'd7);
    add_write(CFG_INDEX_W'(8'h80), '0);
    add_write(CFG_INDEX_W'(4), 32'd5);
    add_write(REG_INITIAL_LEVEL, 32'd3);
    add_item(1'b1, 32'd100, 1'b1, 1'b1);
    add_item(1'b0, 32'd6, 1'b0, 1'b0);
    add_item(1'b0, 32'd1, 1'b0, 1'b0);
    add_item(1'b1, 32'd2, 1'b0, 1'b0);
    add_item(1'b1, 32'd1, 1'b0, 1'b0);
    // back to decay
    add_write(REG_CLEAR_MODE, 32'h2);
    add_write(REG_INITIAL_LEVEL, '0);
    add_item(1'b1, 32'd2, 1'b0, 1'b0);
    add_item(1'b0, 32'd1, 1'b0, 1'b0);
    add_item(1'b1, 32'd1, 1'b0, 1'b0);
    add_item(1'b1, 32'd1, 1'b0, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    in_gap_pct = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      else
        send_level(dir_rows[i].raw, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].level);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_RISE_DELAY, '0);
          write_reg(REG_FALL_DELAY, '0);
        end
        1: begin
          write_reg(REG_RISE_DELAY, '1);
          write_reg(REG_FALL_DELAY, '1);
        end
        2: begin
          write_reg(REG_RISE_DELAY, '0);
          write_reg(REG_FALL_DELAY, '1);
        end
        default: begin
          write_reg(REG_RISE_DELAY, pick_delay());
          write_reg(REG_FALL_DELAY, pick_delay());
        end
      endcase
      write_reg(REG_CLEAR_MODE, $urandom);
      write_reg(REG_INITIAL_LEVEL, $urandom);
      if ($urandom_range(2) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(4, (1 << CFG_INDEX_W) - 1)), $urandom);

      quiet = (ph >= N_PHASES - 2);
      r = $urandom_range(2);
      in_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
      r = $urandom_range(2);
      stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        run_level = $urandom_range(1);
        run_len = $urandom_range(1, 12);
        span = 64'(run_level ? on_delay : off_delay) / $urandom_range(2, 6) + 64'd1;
        for (int k = 0; k < run_len && n < ITEMS_PER_PHASE; k++) begin
          r = $urandom_range(19);
          if (r == 0) el = '0;
          else if (r == 1) el = '1;
          else if (r <= 3) el = $urandom;
          else el = ELAPSED_W'($urandom_range(0, 32'(span)));
          // bounce against the run now and then
          raw = ($urandom_range(9) == 0) ? !run_level : run_level;
          send_level(raw, el, 1'b0, 1'b0);
          n++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("asymmetric_time_debounce test passed");
    end else begin
      $display("asymmetric_time_debounce test failed");
    end
    $finish;
  end

endmodule
